// File: hw/rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// shared types and constants of the bitmap page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int PAGE_W          = 15;
    localparam int ACTION_W        = 2;
    localparam int CFG_W           = 13;
    localparam int BYTE_W          = 8;
    localparam int BIT_IDX_W       = 3;
    localparam int PAGE_SPACE_BYTES = 4096;
    localparam int MAP_BYTES_DEF   = 4096;

    localparam logic [BYTE_W-1:0] FULL_BYTE     = 8'hFF;
    localparam logic [CFG_W-1:0]  BYTES_IN_USE_RST = 13'd4096;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_FREE    = 2'd1,
        ACT_RESERVE = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_IDLE,
        ST_CHECK,
        ST_EXAMINE
    } t_state;

endpackage

// File: hw/rtl/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// first-fit physical page allocator over a one-bit-per-page used map
// ----------------------------------------------------------------------------
// After reset the block sweeps the map and marks every page used, one byte a
// cycle, taking no request until all min(MAP_BYTES, 4096) bytes are written
// (the bytes_in_use register can be written during the sweep). The map sits
// in a single-port byte memory and one index register, incrementer and limit
// compare are shared by every request type. A free or reserve request reads
// its byte in the check state and writes it back in the examine state; one
// of a page past the bytes in use (capped at the map depth), or a request
// with the unused action code, is refused in the check state. An allocate
// scans from byte 0 to the first non-full byte, one memory read per byte in
// the check state and the registered read data tested in the examine state;
// one that finds no free page is refused when the scan hits the limit. One
// request is worked on at a time; a new request is taken only when the
// output register is empty or hands its result on in the same cycle.
module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int MAP_BYTES = MAP_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [PAGE_W-1:0]   i_page_number,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_ok,
    output logic [PAGE_W-1:0]   o_granted_page
);

    localparam int DEPTH = (MAP_BYTES < PAGE_SPACE_BYTES) ? MAP_BYTES : PAGE_SPACE_BYTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CFG_W-1:0] LAST_IDX = CFG_W'(DEPTH - 1);
    localparam logic [CFG_W-1:0] DEPTH_C  = CFG_W'(DEPTH);

    logic [BYTE_W-1:0] mem [DEPTH];

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_bytes_in_use;
    logic [CFG_W-1:0]   r_idx, n_idx;
    t_action            r_action, n_action;
    logic [BIT_IDX_W-1:0] r_bit, n_bit;
    logic [BYTE_W-1:0]  r_rd_data;
    logic               r_out_valid, n_out_valid;
    logic               r_ok, n_ok;
    logic [PAGE_W-1:0]  r_granted, n_granted;

    logic               in_take;
    logic               out_take;
    logic [CFG_W-1:0]   limit;
    logic               in_range;
    logic               mem_we;
    logic               mem_re;
    logic [BYTE_W-1:0]  mem_wdata;
    logic [BIT_IDX_W-1:0] free_bit;
    logic               is_full;
    logic [BYTE_W-1:0]  bit_mask;

    assign limit    = (r_bytes_in_use > DEPTH_C) ? DEPTH_C : r_bytes_in_use;
    assign in_range = (r_idx < limit);
    assign is_full  = (r_rd_data == FULL_BYTE);
    assign out_take = r_out_valid && !i_out_stall;
    assign in_take  = i_in_valid && !o_in_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && (!r_out_valid || !i_out_stall));

    // lowest clear bit
    always_comb begin
        free_bit = '0;
        for (int b = BYTE_W - 1; b >= 0; b--) begin
            if (!r_rd_data[b]) begin
                free_bit = BIT_IDX_W'(b);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_FILL: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_take) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (in_range && r_action != ACT_NONE) begin
                    n_state = ST_EXAMINE;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EXAMINE: begin
                if (r_action == ACT_ALLOC && is_full) begin
                    n_state = ST_CHECK;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_idx       = r_idx;
        n_action    = r_action;
        n_bit       = r_bit;
        n_out_valid = r_out_valid && !out_take;
        n_ok        = r_ok;
        n_granted   = r_granted;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_wdata   = FULL_BYTE;
        bit_mask    = '0;
        unique case (r_state)
            ST_FILL: begin
                mem_we = 1'b1;
                n_idx  = r_idx + 1'b1;
            end
            ST_IDLE: begin
                if (in_take) begin
                    n_action = t_action'(i_action);
                    n_bit    = i_page_number[BIT_IDX_W-1:0];
                    if (t_action'(i_action) == ACT_ALLOC) begin
                        n_idx = '0;
                    end else begin
                        n_idx = CFG_W'(i_page_number[PAGE_W-1:BIT_IDX_W]);
                    end
                end
            end
            ST_CHECK: begin
                if (in_range && r_action != ACT_NONE) begin
                    mem_re = 1'b1;
                end else begin
                    n_out_valid = 1'b1;
                    n_ok        = 1'b0;
                    n_granted   = '0;
                end
            end
            ST_EXAMINE: begin
                if (r_action == ACT_ALLOC) begin
                    if (is_full) begin
                        n_idx = r_idx + 1'b1;
                    end else begin
                        bit_mask    = BYTE_W'(1) << free_bit;
                        mem_we      = 1'b1;
                        mem_wdata   = r_rd_data | bit_mask;
                        n_out_valid = 1'b1;
                        n_ok        = 1'b1;
                        n_granted   = PAGE_W'({r_idx, free_bit});
                    end
                end else begin
                    bit_mask    = BYTE_W'(1) << r_bit;
                    mem_we      = 1'b1;
                    mem_wdata   = (r_action == ACT_FREE) ? (r_rd_data & ~bit_mask)
                                                         : (r_rd_data | bit_mask);
                    n_out_valid = 1'b1;
                    n_ok        = 1'b1;
                    n_granted   = '0;
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_idx[AW-1:0]] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_FILL;
            r_idx          <= '0;
            r_bytes_in_use <= BYTES_IN_USE_RST;
            r_out_valid    <= 1'b0;
            r_action       <= ACT_NONE;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            r_action    <= n_action;
            if (i_cfg_we) begin
                r_bytes_in_use <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit     <= n_bit;
        r_ok      <= n_ok;
        r_granted <= n_granted;
    end

    assign o_out_valid    = r_out_valid;
    assign o_ok           = r_ok;
    assign o_granted_page = r_granted;

endmodule
